[hw/rtl/ppode_pkg.sv]
// ----------------------------------------------------------------------------
// ppode_pkg: shared types, constants and saturating helpers
// Fixed-point format, command and status bundles, and the saturating add,
// negate, halve and product rounding used by the predator-prey stepper.
// ----------------------------------------------------------------------------
package ppode_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int CNT_WIDTH     = 20;
    localparam int STEP_WIDTH    = 31;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;

    // Shared multiplier: signed operands one bit wider than a value so that
    // magnitudes and unsigned constants fit.
    localparam int MUL_WIDTH  = VALUE_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * MUL_WIDTH;

    // n / 6 for n below 2**32 equals (n * 0xAAAAAAAB) >> 34.
    localparam logic signed [MUL_WIDTH-1:0] DIV6_RECIP = 33'sh0_AAAA_AAAB;
    localparam int DIV6_SHIFT = 34;

    localparam int S_TDATA_WIDTH = 2 * VALUE_WIDTH;
    localparam int M_FIELD_WIDTH = 2 * VALUE_WIDTH + CNT_WIDTH;
    localparam int M_TDATA_WIDTH = ((M_FIELD_WIDTH + 7) / 8) * 8;

    typedef logic signed [VALUE_WIDTH-1:0] t_val;

    localparam t_val VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_val VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PREY_GROWTH    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PREY_PREDATION = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRED_DEATH     = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRED_GAIN      = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_SIZE      = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_METHOD         = 3'd6;

    localparam t_val                   RST_COEF   = 32'sd65536;
    localparam logic [STEP_WIDTH-1:0]  RST_STEP   = 31'd655;
    localparam logic [CNT_WIDTH-1:0]   RST_LIMIT  = 20'd1000;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_STEP   = 1'b1;
    localparam logic METHOD_EULER = 1'b0;
    localparam logic METHOD_RK4   = 1'b1;

    // Multiplier operations; each names its operands and its write-back.
    typedef enum logic [2:0] {
        MOP_M1,   // prey_predation * y   -> a = growth - p
        MOP_M2,   // pred_gain * x        -> b = p - death
        MOP_FX,   // a * x                -> fx
        MOP_FY,   // b * y                -> fy
        MOP_KX,   // h * fx               -> kx
        MOP_KY,   // h * fy               -> ky
        MOP_DX,   // |acc_x| / 6          -> prey update
        MOP_DY    // |acc_y| / 6          -> predator update
    } t_mop;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOPE,
        ST_COMB,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       mop_valid;
        t_mop       mop;
        logic       comb;
        logic [1:0] stage;
        logic       bump;
        logic       out_load;
        logic       out_done;
    } t_cmd;

    typedef struct packed {
        logic method;
        logic past_limit;
    } t_status;

    function automatic t_val sat_add(input t_val a, input t_val b);
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

    function automatic t_val sat_neg(input t_val a);
        if (a == VMIN) begin
            return VMAX;
        end
        return -a;
    endfunction

    // Halving that truncates toward zero.
    function automatic t_val half_tz(input t_val a);
        t_val t;
        t = a + {{(VALUE_WIDTH-1){1'b0}}, a[VALUE_WIDTH-1]};
        return t >>> 1;
    endfunction

    // Round to nearest, ties away from zero, then saturate to a value.
    function automatic t_val round_sat(input logic signed [PROD_WIDTH-1:0] p);
        logic signed [PROD_WIDTH-1:0] r;
        logic signed [PROD_WIDTH-1:0] half;
        logic signed [PROD_WIDTH-1:0] pmax;
        logic signed [PROD_WIDTH-1:0] pmin;
        half = {{(PROD_WIDTH-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};
        pmax = VMAX;
        pmin = VMIN;
        r = p + half;
        if (p[PROD_WIDTH-1]) begin
            r = r - 1;
        end
        r = r >>> FRACTION_BITS;
        if (r > pmax) begin
            return VMAX;
        end
        if (r < pmin) begin
            return VMIN;
        end
        return r[VALUE_WIDTH-1:0];
    endfunction

endpackage

[hw/rtl/ppode_dp.sv]
// ----------------------------------------------------------------------------
// ppode_dp: stepper datapath
// Configuration and state registers, the shared multiplier with its rounding
// write-back stage, the Euler and RK4 combine logic and the output register.
// ----------------------------------------------------------------------------
module ppode_dp (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [ppode_pkg::CFG_IDX_WIDTH-1:0]       i_cfg_idx,
    input  logic [ppode_pkg::CFG_DATA_WIDTH-1:0]      i_cfg_data,
    input  logic [ppode_pkg::S_TDATA_WIDTH-1:0]       i_s_tdata,
    input  ppode_pkg::t_cmd                           i_cmd,
    output ppode_pkg::t_status                        o_status,
    output logic [ppode_pkg::VALUE_WIDTH-1:0]         o_prey,
    output logic [ppode_pkg::VALUE_WIDTH-1:0]         o_pred,
    output logic [ppode_pkg::CNT_WIDTH-1:0]           o_idx,
    output logic                                      o_done
);
    import ppode_pkg::*;

    t_val                    r_growth, r_predation, r_death, r_gain;
    logic [STEP_WIDTH-1:0]   r_h;
    logic [CNT_WIDTH-1:0]    r_limit;
    logic                    r_method;

    t_val                    r_prey, r_pred;
    logic [CNT_WIDTH-1:0]    r_cnt;

    t_val                    r_xs, r_ys, r_a, r_b, r_fx, r_fy, r_kx, r_ky;
    t_val                    r_accx, r_accy;
    logic signed [PROD_WIDTH-1:0] r_prod;
    t_mop                    r_tag;
    logic                    r_tag_vld;

    logic signed [MUL_WIDTH-1:0]  opa, opb;
    logic signed [PROD_WIDTH-1:0] n_prod;
    t_val                    rnd, quo, qsign;
    logic [CNT_WIDTH:0]      next_idx;

    function automatic logic signed [MUL_WIDTH-1:0] sx(input t_val v);
        return {v[VALUE_WIDTH-1], v};
    endfunction

    function automatic logic signed [MUL_WIDTH-1:0] mag(input t_val v);
        logic signed [MUL_WIDTH-1:0] e;
        e = {v[VALUE_WIDTH-1], v};
        return v[VALUE_WIDTH-1] ? -e : e;
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.mop)
            MOP_M1: begin opa = sx(r_predation);        opb = sx(r_ys); end
            MOP_M2: begin opa = sx(r_gain);             opb = sx(r_xs); end
            MOP_FX: begin opa = sx(r_a);                opb = sx(r_xs); end
            MOP_FY: begin opa = sx(r_b);                opb = sx(r_ys); end
            MOP_KX: begin opa = {2'b00, r_h};           opb = sx(r_fx); end
            MOP_KY: begin opa = {2'b00, r_h};           opb = sx(r_fy); end
            MOP_DX: begin opa = mag(r_accx);            opb = DIV6_RECIP; end
            MOP_DY: begin opa = mag(r_accy);            opb = DIV6_RECIP; end
            default: begin opa = '0;                    opb = '0; end
        endcase
        n_prod = opa * opb;
    end

    // Write-back stage: rounded product, or quotient by six with the sign
    // of the running sum put back.
    always_comb begin
        rnd = round_sat(r_prod);
        quo = r_prod[DIV6_SHIFT +: VALUE_WIDTH];
        if (r_tag == MOP_DX) begin
            qsign = r_accx[VALUE_WIDTH-1] ? -quo : quo;
        end else begin
            qsign = r_accy[VALUE_WIDTH-1] ? -quo : quo;
        end
    end

    assign next_idx = {1'b0, r_cnt} + {{CNT_WIDTH{1'b0}}, 1'b1};
    assign o_status.past_limit = next_idx > {1'b0, r_limit};
    assign o_status.method     = r_method;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_growth    <= RST_COEF;
            r_predation <= RST_COEF;
            r_death     <= RST_COEF;
            r_gain      <= RST_COEF;
            r_h         <= RST_STEP;
            r_limit     <= RST_LIMIT;
            r_method    <= METHOD_RK4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PREY_GROWTH:    r_growth    <= i_cfg_data[VALUE_WIDTH-1:0];
                CFG_PREY_PREDATION: r_predation <= i_cfg_data[VALUE_WIDTH-1:0];
                CFG_PRED_DEATH:     r_death     <= i_cfg_data[VALUE_WIDTH-1:0];
                CFG_PRED_GAIN:      r_gain      <= i_cfg_data[VALUE_WIDTH-1:0];
                CFG_STEP_SIZE:      r_h         <= i_cfg_data[STEP_WIDTH-1:0];
                CFG_STEP_LIMIT:     r_limit     <= i_cfg_data[CNT_WIDTH-1:0];
                CFG_METHOD:         r_method    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Multiplier stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld <= 1'b0;
        end else begin
            r_tag_vld <= i_cmd.mop_valid;
        end
        r_prod <= n_prod;
        r_tag  <= i_cmd.mop;
    end

    // State, slope and accumulator registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prey <= '0;
            r_pred <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_prey <= i_s_tdata[VALUE_WIDTH-1:0];
                r_pred <= i_s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
                r_cnt  <= '0;
            end
            if (i_cmd.bump) begin
                r_cnt <= next_idx[CNT_WIDTH-1:0];
            end
            if (i_cmd.comb && r_method == METHOD_EULER) begin
                r_prey <= sat_add(r_prey, r_kx);
                r_pred <= sat_add(r_pred, r_ky);
            end
            if (r_tag_vld && r_tag == MOP_DX) begin
                r_prey <= sat_add(r_prey, qsign);
            end
            if (r_tag_vld && r_tag == MOP_DY) begin
                r_pred <= sat_add(r_pred, qsign);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_xs <= r_prey;
            r_ys <= r_pred;
        end
        if (r_tag_vld) begin
            case (r_tag)
                MOP_M1: r_a  <= sat_add(r_growth, sat_neg(rnd));
                MOP_M2: r_b  <= sat_add(sat_neg(r_death), rnd);
                MOP_FX: r_fx <= rnd;
                MOP_FY: r_fy <= rnd;
                MOP_KX: r_kx <= rnd;
                MOP_KY: r_ky <= rnd;
                default: begin
                end
            endcase
        end
        if (i_cmd.comb && r_method == METHOD_RK4) begin
            case (i_cmd.stage)
                2'd0: begin
                    r_accx <= r_kx;
                    r_accy <= r_ky;
                    r_xs   <= sat_add(r_prey, half_tz(r_kx));
                    r_ys   <= sat_add(r_pred, half_tz(r_ky));
                end
                2'd1: begin
                    r_accx <= sat_add(r_accx, sat_add(r_kx, r_kx));
                    r_accy <= sat_add(r_accy, sat_add(r_ky, r_ky));
                    r_xs   <= sat_add(r_prey, half_tz(r_kx));
                    r_ys   <= sat_add(r_pred, half_tz(r_ky));
                end
                2'd2: begin
                    r_accx <= sat_add(r_accx, sat_add(r_kx, r_kx));
                    r_accy <= sat_add(r_accy, sat_add(r_ky, r_ky));
                    r_xs   <= sat_add(r_prey, r_kx);
                    r_ys   <= sat_add(r_pred, r_ky);
                end
                default: begin
                    r_accx <= sat_add(r_accx, r_kx);
                    r_accy <= sat_add(r_accy, r_ky);
                end
            endcase
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_prey <= r_prey;
            o_pred <= r_pred;
            o_idx  <= r_cnt;
            o_done <= i_cmd.out_done;
        end
    end

    a_load_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_cnt == '0))
        else $error("step counter not cleared by a load");

endmodule

[hw/rtl/ppode_ctrl.sv]
// ----------------------------------------------------------------------------
// ppode_ctrl: stepper sequencer
// Accepts items, issues the multiplier operation sequence for each slope
// evaluation, the combine and divide steps, and hands results to the output.
// ----------------------------------------------------------------------------
module ppode_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_kind,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  ppode_pkg::t_status  i_status,
    output ppode_pkg::t_cmd     o_cmd
);
    import ppode_pkg::*;

    t_state      r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic [1:0]  r_stage, n_stage;
    logic        r_done, n_done;
    logic        r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_stage     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_stage     <= n_stage;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_stage  = r_stage;
        n_done   = r_done;
        o_cmd    = '0;
        o_cmd.mop      = MOP_M1;
        o_cmd.stage    = r_stage;
        o_cmd.out_done = r_done;
        o_s_tready = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;

        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_kind == KIND_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_done  = 1'b0;
                        n_state = ST_DONE;
                    end else if (i_status.past_limit) begin
                        n_done  = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_done  = 1'b0;
                        n_stage = '0;
                        n_cnt   = '0;
                        n_state = ST_SLOPE;
                    end
                end
            end
            ST_SLOPE: begin
                // Six back-to-back products, then a drain step that issues none.
                o_cmd.mop_valid = (r_cnt != 3'd6);
                case (r_cnt)
                    3'd0:    o_cmd.mop = MOP_M1;
                    3'd1:    o_cmd.mop = MOP_M2;
                    3'd2:    o_cmd.mop = MOP_FX;
                    3'd3:    o_cmd.mop = MOP_FY;
                    3'd4:    o_cmd.mop = MOP_KX;
                    3'd5:    o_cmd.mop = MOP_KY;
                    default: o_cmd.mop = MOP_M1;
                endcase
                if (r_cnt == 3'd6) begin
                    n_cnt   = '0;
                    n_state = ST_COMB;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_COMB: begin
                o_cmd.comb = 1'b1;
                if (i_status.method == METHOD_EULER) begin
                    o_cmd.bump = 1'b1;
                    n_state = ST_DONE;
                end else if (r_stage == 2'd3) begin
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_stage = r_stage + 2'd1;
                    n_state = ST_SLOPE;
                end
            end
            ST_DIV: begin
                o_cmd.mop_valid = (r_cnt != 3'd2);
                o_cmd.mop = (r_cnt == 3'd0) ? MOP_DX : MOP_DY;
                if (r_cnt == 3'd2) begin
                    o_cmd.bump = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;

    a_past_limit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_s_tvalid && i_kind == KIND_STEP && i_status.past_limit)
        |=> (r_state == ST_DONE && r_done))
        else $error("past-limit step did not go straight to done");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result valid raised outside the done state");

    a_bump_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.bump |=> (r_state == ST_DONE && !r_done))
        else $error("counter advanced without a computed result following");

    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mop_valid |-> !o_s_tready)
        else $error("multiplier issued while accepting input");

endmodule

[hw/rtl/predator_prey_ode_stepper_unit.sv]
// ----------------------------------------------------------------------------
// predator_prey_ode_stepper_unit: Lotka-Volterra Euler / RK4 stepper
// A load or a step past the limit goes from idle straight to the done state,
// which raises o_m_tvalid; an Euler step runs a slope and a combine, an RK4
// step its slopes, combines and the divide. Items are taken one at a time,
// set by the single shared 33x33 multiplier and the dependent slope chain.
// Reset (synchronous, active low) restores the register defaults and zeroes
// the populations and the step counter.
// ----------------------------------------------------------------------------
module predator_prey_ode_stepper_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [ppode_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [ppode_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    // Input stream.
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata, low bit first: prey_init[31:0], pred_init[63:32]
    input  logic [ppode_pkg::S_TDATA_WIDTH-1:0]    i_s_tdata,
    // tuser: kind (0 load, 1 step)
    input  logic                                   i_s_tuser,
    // Result stream.
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // tdata, low bit first: prey_out[31:0], pred_out[63:32],
    // step_index[83:64], zero padding[87:84]
    output logic [ppode_pkg::M_TDATA_WIDTH-1:0]    o_m_tdata,
    // tuser: done_res
    output logic                                   o_m_tuser
);
    import ppode_pkg::*;

    // The sequencer owns all timing; the datapath holds every value. The
    // sequencer issues one multiplier operation per cycle during a slope
    // evaluation, and the datapath writes each rounded product back from the
    // multiplier stage register in the next cycle.
    t_cmd                   cmd;
    t_status                status;
    logic [VALUE_WIDTH-1:0] prey_q, pred_q;
    logic [CNT_WIDTH-1:0]   idx_q;

    ppode_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ppode_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_prey     (prey_q),
        .o_pred     (pred_q),
        .o_idx      (idx_q),
        .o_done     (o_m_tuser)
    );

    // Pack the result fields; the padding up to a whole byte is zero.
    assign o_m_tdata = {{(M_TDATA_WIDTH-M_FIELD_WIDTH){1'b0}}, idx_q, pred_q, prey_q};

endmodule
